>>> design/spld_pkg.sv
// Package for the six-position ladder switch debouncer.
// Holds register indexes, field widths, reset values and the small decode functions.
// No dependencies.
package spld_pkg;

  localparam int SampleWidth    = 12;
  localparam int PosWidth       = 3;
  localparam int MaskWidth      = 6;
  localparam int CountWidth     = 3;
  localparam int IndicatorWidth = 13;
  localparam int CfgIndexWidth  = 3;
  localparam int CfgDataWidth   = 12;
  localparam int InTdataWidth   = 16;
  localparam int OutTdataWidth  = 24;

  localparam logic [MaskWidth-1:0]      MaskAll        = 6'h3F;
  localparam logic [IndicatorWidth-1:0] IndicatorStep  = 13'd819;

  localparam logic [SampleWidth-1:0] ThreshPos1Reset = 12'd3800;
  localparam logic [SampleWidth-1:0] ThreshPos2Reset = 12'd3100;
  localparam logic [SampleWidth-1:0] ThreshPos3Reset = 12'd2300;
  localparam logic [SampleWidth-1:0] ThreshPos4Reset = 12'd1500;
  localparam logic [SampleWidth-1:0] ThreshPos5Reset = 12'd1000;
  localparam logic [SampleWidth-1:0] ThreshPos6Reset = 12'd400;
  localparam logic [CountWidth-1:0]  StableReset     = 3'd2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_THRESH_POS1  = 3'd0,
    REG_THRESH_POS2  = 3'd1,
    REG_THRESH_POS3  = 3'd2,
    REG_THRESH_POS4  = 3'd3,
    REG_THRESH_POS5  = 3'd4,
    REG_THRESH_POS6  = 3'd5,
    REG_STABLE_COUNT = 3'd6
  } cfg_reg_t;

  typedef logic [PosWidth-1:0] position_t;

  // Active-low mask: position N clears bit N-1, position 0 leaves all ones.
  function automatic logic [MaskWidth-1:0] mask_for(input position_t pos);
    logic [MaskWidth-1:0] m;
    m = MaskAll;
    if (pos != '0 && pos <= position_t'(MaskWidth)) begin
      m[pos - position_t'(1)] = 1'b0;
    end
    return m;
  endfunction

  // 819 * (7 - pos), zero for position 0; a small constant table.
  function automatic logic [IndicatorWidth-1:0] indicator_for(input position_t pos);
    logic [IndicatorWidth-1:0] v;
    unique case (pos)
      3'd1:    v = IndicatorStep * 13'd6;
      3'd2:    v = IndicatorStep * 13'd5;
      3'd3:    v = IndicatorStep * 13'd4;
      3'd4:    v = IndicatorStep * 13'd3;
      3'd5:    v = IndicatorStep * 13'd2;
      3'd6:    v = IndicatorStep;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/six_position_ladder_switch_debouncer_unit.sv
// Six-position ladder switch debouncer: top level.
// Sample register, classify/debounce logic and result register in one module.
// Depends on spld_pkg.
//
// Path: an accepted sample is held in the sample register, then its result in the
//   result register, which drives the master side.
// Throughput: one sample per cycle; a stalled result back-pressures through the
//   sample register, so the slave side stays ready while that register can drain.
// Reset (rst, synchronous, active high): thresholds and stable count to their
//   defaults, debounce state cleared, mask all ones, sticky position zero.
module six_position_ladder_switch_debouncer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Slave side: tdata = adc_sample[11:0], zero padded to 16 bits
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [spld_pkg::InTdataWidth-1:0]   s_tdata,
  // Master side: tdata = switch_mask[5:0], sticky_position[8:6],
  //   indicator_value[21:9], zero padded to 24 bits
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [spld_pkg::OutTdataWidth-1:0]  m_tdata,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [spld_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [spld_pkg::CfgDataWidth-1:0]   cfg_data
);
  import spld_pkg::*;

  // Configuration registers
  logic [SampleWidth-1:0] thresh_pos1, thresh_pos2, thresh_pos3;
  logic [SampleWidth-1:0] thresh_pos4, thresh_pos5, thresh_pos6;
  logic [CountWidth-1:0]  stable_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_pos1    <= ThreshPos1Reset;
      thresh_pos2    <= ThreshPos2Reset;
      thresh_pos3    <= ThreshPos3Reset;
      thresh_pos4    <= ThreshPos4Reset;
      thresh_pos5    <= ThreshPos5Reset;
      thresh_pos6    <= ThreshPos6Reset;
      stable_samples <= StableReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESH_POS1:  thresh_pos1    <= cfg_data;
        REG_THRESH_POS2:  thresh_pos2    <= cfg_data;
        REG_THRESH_POS3:  thresh_pos3    <= cfg_data;
        REG_THRESH_POS4:  thresh_pos4    <= cfg_data;
        REG_THRESH_POS5:  thresh_pos5    <= cfg_data;
        REG_THRESH_POS6:  thresh_pos6    <= cfg_data;
        REG_STABLE_COUNT: stable_samples <= cfg_data[CountWidth-1:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // Sample register
  logic                   smp_valid;
  logic [SampleWidth-1:0] smp_data;
  logic                   advance;

  // A sample moves on when the result register is empty or being drained.
  assign advance  = smp_valid && (!m_tvalid || m_tready);
  assign s_tready = !smp_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (s_tready) begin
      smp_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      smp_data <= s_tdata[SampleWidth-1:0];
    end
  end

  // Classification: first threshold passed wins, whatever their order.
  position_t cur_pos;
  always_comb begin
    priority if (smp_data > thresh_pos1) cur_pos = 3'd1;
    else if (smp_data > thresh_pos2)     cur_pos = 3'd2;
    else if (smp_data > thresh_pos3)     cur_pos = 3'd3;
    else if (smp_data > thresh_pos4)     cur_pos = 3'd4;
    else if (smp_data > thresh_pos5)     cur_pos = 3'd5;
    else if (smp_data > thresh_pos6)     cur_pos = 3'd6;
    else                                 cur_pos = 3'd0;
  end

  // Debounce state; committed mask, held position and indicator double as
  // the result register.
  position_t                last_seen, last_seen_next;
  logic [CountWidth-1:0]    debounce_count, debounce_count_next;
  logic [MaskWidth-1:0]     committed_mask, committed_mask_next;
  position_t                held_pos, held_pos_next;
  logic [IndicatorWidth-1:0] indicator, indicator_next;

  always_comb begin
    last_seen_next      = last_seen;
    debounce_count_next = debounce_count;
    committed_mask_next = committed_mask;
    held_pos_next       = held_pos;
    if (cur_pos != last_seen) begin
      // new position: reload the countdown
      last_seen_next      = cur_pos;
      debounce_count_next = stable_samples;
    end else if (debounce_count != '0) begin
      debounce_count_next = debounce_count - CountWidth'(1);
      if (debounce_count == CountWidth'(1)) begin
        committed_mask_next = mask_for(cur_pos);
        if (cur_pos != '0) begin
          held_pos_next = cur_pos;
        end
      end
    end
    indicator_next = indicator_for(held_pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seen      <= '0;
      debounce_count <= '0;
      committed_mask <= MaskAll;
      held_pos       <= '0;
      indicator      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (advance) begin
        last_seen      <= last_seen_next;
        debounce_count <= debounce_count_next;
        committed_mask <= committed_mask_next;
        held_pos       <= held_pos_next;
        indicator      <= indicator_next;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {2'b00, indicator, held_pos, committed_mask};

  // Mask never has more than one switch asserted.
  a_mask_one_hot_low: assert property (@(posedge clk) disable iff (rst)
    $countones(~committed_mask) <= 1)
    else $error("switch mask has more than one bit low");

  // Indicator tracks the held position.
  a_indicator_match: assert property (@(posedge clk) disable iff (rst)
    indicator == indicator_for(held_pos))
    else $error("indicator out of step with held position");

  // A changed position reloads the countdown from the configured count.
  a_reload: assert property (@(posedge clk) disable iff (rst)
    advance && (cur_pos != last_seen) |=> debounce_count == $past(stable_samples))
    else $error("debounce countdown not reloaded on change");

  // A stalled result keeps the state frozen.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(held_pos) && $stable(debounce_count))
    else $error("state moved while result stalled");

endmodule
